### sv/easing_curve_shaper_unit_assert.svh
// Assertion macros shared by the easing curve shaper RTL.
`ifndef EASING_CURVE_SHAPER_UNIT_ASSERT_SVH
`define EASING_CURVE_SHAPER_UNIT_ASSERT_SVH
// Same-cycle implication, disabled while reset is high.
`define ECS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("easing curve shaper assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ECS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("easing curve shaper assertion failed");
`endif

### sv/ecs_pkg.sv
// Shared constants, types and table contents of the easing curve shaper.
package ecs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 256;
  localparam int PHASE_W     = FRAC_BITS + 1;
  localparam int LEVEL_W     = FRAC_BITS + 2;
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ROM_W       = 31;
  localparam int N_W         = 4;
  localparam int SH_W        = 6;
  localparam int CURVE_W     = 3;

  localparam logic [CURVE_W-1:0] CURVE_SINE      = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_EXP       = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_LOG       = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_STEP_NOW  = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_STEP_WAIT = 3'd4;
  localparam logic [CURVE_W-1:0] CURVE_IN_BACK   = 3'd5;
  localparam logic [CURVE_W-1:0] CURVE_OUT_BACK  = 3'd6;
  localparam logic [CURVE_W-1:0] CURVE_REBOUND   = 3'd7;

  localparam longint ONE         = longint'(1) << FRAC_BITS;
  localparam longint STEP_THRESH = (ONE * 99999 + 99999) / 100000;

  localparam logic [63:0] Q30     = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] BACK_K  = 64'd1827057613;
  localparam logic [63:0] BACK_KA = BACK_K + Q30;
  localparam int          KA_W    = 32;

  typedef logic [0:TABLE_DEPTH][ROM_W-1:0] rom_t;

  typedef struct packed {
    logic [ROM_W-1:0] iv;  // interpolated Q30 table value
    logic [N_W-1:0]   n;   // extra right shift (integer part of exponent)
  } lut_res_t;

  typedef struct packed {
    logic               back_neg;
    logic [PHASE_W-1:0] back_mag;
    logic [PHASE_W-1:0] bounce;
  } poly_res_t;

  // Raised cosine (1 - cos(pi x)) / 2 in Q30, Taylor series with truncating terms.
  function automatic rom_t build_sine_rom();
    rom_t        rom;
    logic [63:0] j;
    logic [63:0] ang;
    logic [63:0] x2;
    logic [63:0] term;
    longint      c;
    longint      v;
    logic        mirror;
    rom = '0;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      mirror = (2 * i > TABLE_DEPTH);
      j = mirror ? 64'(TABLE_DEPTH - i) : 64'(i);
      ang = (PI_Q30 * j + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
      x2 = (ang * ang + (Q30 >> 1)) >> 30;
      term = Q30;
      c = longint'(Q30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if ((k & 1) != 0) c = c - longint'(term);
        else c = c + longint'(term);
      end
      v = mirror ? (longint'(Q30) + c) : (longint'(Q30) - c);
      if (v < 0) v = 0;
      if (v > 2 * longint'(Q30)) v = 2 * longint'(Q30);
      rom[i] = ROM_W'((v + 1) >>> 1);
    end
    return rom;
  endfunction

  // 2^(-i/TABLE_DEPTH) in Q30 by the series of exp(-t ln2).
  function automatic rom_t build_exp_rom();
    rom_t        rom;
    logic [63:0] t;
    logic [63:0] term;
    longint      s;
    rom = '0;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      t = (LN2_Q30 * 64'(i) + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
      term = Q30;
      s = longint'(Q30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 30) / 64'(k);
        if ((k & 1) != 0) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      rom[i] = ROM_W'(s);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();
  localparam rom_t EXP_ROM  = build_exp_rom();

endpackage

### sv/ecs_interp.sv
// Four-stage table lookup with linear interpolation for the sine, exp and log curves.
module ecs_interp import ecs_pkg::*; (
  input  logic               clk,
  input  logic [PHASE_W-1:0] x,
  input  logic [CURVE_W-1:0] sel,
  output lut_res_t           res
);

  localparam int U_W    = PHASE_W + 4;
  localparam int PROD_W = PHASE_W + IDX_W;
  localparam int PR_W   = ROM_W + FRAC_BITS;

  // stage 1: table position and exponent integer part
  logic [PHASE_W-1:0] src;
  logic [U_W-1:0]     u;
  logic [PHASE_W-1:0] pos1;
  logic [N_W-1:0]     n1;
  logic               use_exp1;

  assign src = (sel == CURVE_EXP) ? (PHASE_W'(ONE) - x) : x;
  assign u   = U_W'(src) * U_W'(10);

  always_ff @(posedge clk) begin
    pos1     <= (sel == CURVE_SINE) ? x : PHASE_W'(u[FRAC_BITS-1:0]);
    n1       <= (sel == CURVE_SINE) ? '0 : u[FRAC_BITS +: N_W];
    use_exp1 <= (sel != CURVE_SINE);
  end

  // stage 2: read both neighbors
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     ia;
  logic [IDX_W-1:0]     ib;
  logic                 full;
  logic [ROM_W-1:0]     ta2;
  logic [ROM_W-1:0]     tb2;
  logic [FRAC_BITS-1:0] r2;
  logic [N_W-1:0]       n2;

  assign prod = PROD_W'(pos1) * PROD_W'(TABLE_DEPTH);
  assign idx  = prod[FRAC_BITS +: IDX_W];
  assign full = (idx >= IDX_W'(TABLE_DEPTH));
  assign ia   = full ? IDX_W'(TABLE_DEPTH) : idx;
  assign ib   = full ? IDX_W'(TABLE_DEPTH) : (idx + IDX_W'(1));

  always_ff @(posedge clk) begin
    ta2 <= use_exp1 ? EXP_ROM[ia] : SINE_ROM[ia];
    tb2 <= use_exp1 ? EXP_ROM[ib] : SINE_ROM[ib];
    r2  <= full ? '0 : prod[FRAC_BITS-1:0];
    n2  <= n1;
  end

  // stage 3: scale the difference
  logic             up;
  logic [ROM_W-1:0] diff;
  logic [PR_W-1:0]  prd;
  logic [ROM_W-1:0] ta3;
  logic [ROM_W-1:0] dq3;
  logic             up3;
  logic [N_W-1:0]   n3;

  assign up   = (tb2 >= ta2);
  assign diff = up ? (tb2 - ta2) : (ta2 - tb2);
  assign prd  = PR_W'(diff) * PR_W'(r2);

  always_ff @(posedge clk) begin
    ta3 <= ta2;
    dq3 <= prd[FRAC_BITS +: ROM_W];
    up3 <= up;
    n3  <= n2;
  end

  // stage 4: apply the step
  always_ff @(posedge clk) begin
    res.iv <= up3 ? (ta3 + dq3) : (ta3 - dq3);
    res.n  <= n3;
  end

endmodule

### sv/ecs_poly.sv
// Four-stage polynomial datapath for the back curves and the bounce curve.
module ecs_poly import ecs_pkg::*; (
  input  logic               clk,
  input  logic [PHASE_W-1:0] x,
  input  logic [CURVE_W-1:0] sel,
  output poly_res_t          res
);

  localparam int A_W    = KA_W + PHASE_W;
  localparam int YY_W   = 2 * PHASE_W;
  localparam int X11_W  = PHASE_W + 4;
  localparam int X22_W  = PHASE_W + 5;
  localparam int DD_W   = 2 * X22_W;
  localparam int M30_W  = A_W - FRAC_BITS;
  localparam int MM_W   = M30_W + PHASE_W;

  localparam logic [A_W-1:0]   B_CONST   = A_W'(BACK_K << FRAC_BITS);
  localparam logic [A_W-1:0]   HALF_A    = A_W'(1) << (FRAC_BITS - 1);
  localparam logic [YY_W-1:0]  HALF_YY   = YY_W'(1) << (FRAC_BITS - 1);
  localparam logic [DD_W-1:0]  HALF_DD   = DD_W'(1) << (FRAC_BITS + 5);
  localparam logic [MM_W-1:0]  HALF_MM   = MM_W'(Q30 >> 1);

  // stage 1: back products and bounce segment
  logic [PHASE_W-1:0] y;
  logic [X11_W-1:0]   x11;
  logic [X22_W-1:0]   x22;
  logic [X22_W-1:0]   mo;
  logic [PHASE_W-1:0] off;
  logic [A_W-1:0]     a1;
  logic [YY_W-1:0]    yy1;
  logic [X22_W-1:0]   d1;
  logic [PHASE_W-1:0] off1;

  assign y   = (sel == CURVE_OUT_BACK) ? (PHASE_W'(ONE) - x) : x;
  assign x11 = X11_W'(x) * X11_W'(11);
  assign x22 = X22_W'(x) * X22_W'(22);

  always_comb begin
    if (x11 < X11_W'(4 * ONE)) begin
      mo  = '0;
      off = '0;
    end else if (x11 < X11_W'(8 * ONE)) begin
      mo  = X22_W'(12 * ONE);
      off = PHASE_W'((3 * ONE) / 4);
    end else if (x11 < X11_W'(10 * ONE)) begin
      mo  = X22_W'(18 * ONE);
      off = PHASE_W'((15 * ONE) / 16);
    end else begin
      mo  = X22_W'(21 * ONE);
      off = PHASE_W'((63 * ONE) / 64);
    end
  end

  always_ff @(posedge clk) begin
    a1   <= A_W'(BACK_KA) * A_W'(y);
    yy1  <= YY_W'(y) * YY_W'(y);
    d1   <= (x22 >= mo) ? (x22 - mo) : (mo - x22);
    off1 <= off;
  end

  // stage 2: magnitude, rounded square, bounce square
  logic               neg;
  logic [A_W-1:0]     mag;
  logic [A_W-1:0]     mag_r;
  logic [YY_W-1:0]    yy_r;
  logic [M30_W-1:0]   mag30_2;
  logic [PHASE_W-1:0] q2;
  logic               neg2;
  logic [DD_W-1:0]    dd2;
  logic [PHASE_W-1:0] off2;

  assign neg   = (a1 < B_CONST);
  assign mag   = neg ? (B_CONST - a1) : (a1 - B_CONST);
  assign mag_r = mag + HALF_A;
  assign yy_r  = yy1 + HALF_YY;

  always_ff @(posedge clk) begin
    mag30_2 <= mag_r[FRAC_BITS +: M30_W];
    q2      <= yy_r[FRAC_BITS +: PHASE_W];
    neg2    <= neg;
    dd2     <= DD_W'(d1) * DD_W'(d1);
    off2    <= off1;
  end

  // stage 3: back product, bounce value
  logic [DD_W-1:0]    dd_r;
  logic [MM_W-1:0]    mm3;
  logic               neg3;
  logic [PHASE_W-1:0] bounce3;

  assign dd_r = dd2 + HALF_DD;

  always_ff @(posedge clk) begin
    mm3     <= MM_W'(mag30_2) * MM_W'(q2);
    neg3    <= neg2;
    bounce3 <= dd_r[FRAC_BITS + 6 +: PHASE_W] + off2;
  end

  // stage 4: round the back product down from Q30
  logic [MM_W-1:0] mm_r;

  assign mm_r = mm3 + HALF_MM;

  always_ff @(posedge clk) begin
    res.back_neg <= neg3;
    res.back_mag <= mm_r[30 +: PHASE_W];
    res.bounce   <= bounce3;
  end

endmodule

### sv/easing_curve_shaper_unit.sv
// Easing curve shaper top level: phase in, one shaped level out per transaction.
// Pipeline: a phase accepted gives its level with done high after six register
//   stages counting the output.
// Throughput: one transaction per cycle; busy is low outside reset, nothing stalls.
// Reset (rst, synchronous): clears stage valids, done and curve_sel to sine.
`include "easing_curve_shaper_unit_assert.svh"

module easing_curve_shaper_unit import ecs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [PHASE_W-1:0]        phase,
  input  logic                      curve_select_we,
  input  logic [CURVE_W-1:0]        curve_select,
  output logic                      done,
  output logic signed [LEVEL_W-1:0] level
);

  localparam int LW   = LEVEL_W + 2;
  localparam int SR_W = ROM_W + 2;

  localparam logic signed [LW-1:0] ONE_S   = LW'(ONE);
  localparam logic signed [LW-1:0] LVL_MIN = LW'(-2 * ONE);
  localparam logic signed [LW-1:0] LVL_MAX = LW'(2 * ONE - 1);

  // Curve select reg: users write it only with no transaction in flight; unchecked.
  logic [CURVE_W-1:0] curve_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_sel <= CURVE_SINE;
    end else if (curve_select_we) begin
      curve_sel <= curve_select;
    end
  end

  // Hold off new transactions only while reset is applied.
  assign busy = rst;

  // Stage 0: saturate the phase to 1.0, take the step-wait decision early and
  // tag the transaction with the curve in force. Valid bits advance every cycle.
  logic                 accept;
  logic [4:0]           v;
  logic [PHASE_W-1:0]   x0;
  logic [PHASE_W-1:0]   xc;
  logic [CURVE_W-1:0]   sel_d [0:4];
  logic [4:0]           hit_d;

  assign accept = start && !busy;
  assign xc     = (phase > PHASE_W'(ONE)) ? PHASE_W'(ONE) : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    x0       <= xc;
    sel_d[0] <= curve_sel;
    hit_d    <= {hit_d[3:0], (xc >= PHASE_W'(STEP_THRESH))};
    for (int k = 1; k <= 4; k++) begin
      sel_d[k] <= sel_d[k-1];
    end
  end

  // Stages 1 to 4: table path and polynomial path run side by side and line up
  // with v[4] and sel_d[4].
  lut_res_t  lut_res;
  poly_res_t poly_res;

  ecs_interp u_interp (
    .clk (clk),
    .x   (x0),
    .sel (sel_d[0]),
    .res (lut_res)
  );

  ecs_poly u_poly (
    .clk (clk),
    .x   (x0),
    .sel (sel_d[0]),
    .res (poly_res)
  );

  // Stage 5: round the table value down by 30-FRAC_BITS+n bits, pick the curve,
  // saturate and register the level together with the done strobe.
  logic [SH_W-1:0]         sh;
  logic [SR_W-1:0]         pw_sum;
  logic [SR_W-1:0]         pw_full;
  logic signed [LW-1:0]    pw_s;
  logic signed [LW-1:0]    m_s;
  logic signed [LW-1:0]    back_s;
  logic signed [LW-1:0]    lvl;
  logic signed [LW-1:0]    lvl_c;

  assign sh      = SH_W'(30 - FRAC_BITS) + SH_W'(lut_res.n);
  assign pw_sum  = SR_W'(lut_res.iv) + (SR_W'(1) << (sh - SH_W'(1)));
  assign pw_full = pw_sum >> sh;
  assign pw_s    = $signed(LW'(pw_full[PHASE_W-1:0]));
  assign m_s     = $signed(LW'(poly_res.back_mag));
  assign back_s  = poly_res.back_neg ? -m_s : m_s;

  always_comb begin
    case (sel_d[4])
      CURVE_SINE:      lvl = pw_s;
      CURVE_EXP:       lvl = pw_s;
      CURVE_LOG:       lvl = ONE_S - pw_s;
      CURVE_STEP_NOW:  lvl = ONE_S;
      CURVE_STEP_WAIT: lvl = hit_d[4] ? ONE_S : '0;
      CURVE_IN_BACK:   lvl = back_s;
      CURVE_OUT_BACK:  lvl = ONE_S - back_s;
      default:         lvl = $signed(LW'(poly_res.bounce));
    endcase
  end

  always_comb begin
    if (lvl < LVL_MIN) begin
      lvl_c = LVL_MIN;
    end else if (lvl > LVL_MAX) begin
      lvl_c = LVL_MAX;
    end else begin
      lvl_c = lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    level <= lvl_c[LEVEL_W-1:0];
  end

  // Curve tag and result must stay aligned through the pipeline.
  `ECS_ASSERT_NEXT(a_step_now_one, clk, rst, v[4] && sel_d[4] == CURVE_STEP_NOW, level == LEVEL_W'(ONE))
  `ECS_ASSERT_NEXT(a_exp_nonneg, clk, rst, v[4] && sel_d[4] == CURVE_EXP, !level[LEVEL_W-1])
  `ECS_ASSERT_NEXT(a_sine_nonneg, clk, rst, v[4] && sel_d[4] == CURVE_SINE, !level[LEVEL_W-1])
  `ECS_ASSERT_IMPL(a_bounce_max, clk, rst, v[4] && sel_d[4] == CURVE_REBOUND, poly_res.bounce <= PHASE_W'(ONE))

endmodule

### bench/curve_check.sv
// Checker for the easing curve shaper: predicts each level and compares it with done/level.
module curve_check import ecs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [PHASE_W-1:0]        phase,
  input  logic                      curve_select_we,
  input  logic [CURVE_W-1:0]        curve_select,
  input  logic                      done,
  input  logic signed [LEVEL_W-1:0] level,
  output int                        fail_count,
  output int                        pending,
  output int                        levels_seen
);

  logic [CURVE_W-1:0]        cur_curve;
  logic signed [LEVEL_W-1:0] level_q[$];
  logic [63:0]               sin_tab[0:TABLE_DEPTH];
  logic [63:0]               exp_tab[0:TABLE_DEPTH];

  // Fill both Q30 tables by the truncating series.
  initial begin
    logic [63:0] j, ang, x2, term, t;
    longint      c, v, s;
    logic        mirror;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      mirror = (2 * i > TABLE_DEPTH);
      j = mirror ? 64'(TABLE_DEPTH - i) : 64'(i);
      ang = (64'd3373259426 * j + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
      x2 = (ang * ang + 64'd536870912) >> 30;
      term = 64'd1 << 30;
      c = longint'(64'd1 << 30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) c -= longint'(term);
        else c += longint'(term);
      end
      v = mirror ? (longint'(1) << 30) + c : (longint'(1) << 30) - c;
      if (v < 0) v = 0;
      if (v > (longint'(1) << 31)) v = longint'(1) << 31;
      sin_tab[i] = 64'((v + 1) >>> 1);
      t = (64'd744261118 * 64'(i) + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
      term = 64'd1 << 30;
      s = longint'(64'd1 << 30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 30) / 64'(k);
        if (k % 2 == 1) s -= longint'(term);
        else s += longint'(term);
      end
      if (s < 0) s = 0;
      exp_tab[i] = 64'(s);
    end
  end

  function automatic logic [63:0] lerp(input bit use_exp, input logic [63:0] pos);
    logic [63:0] prod, idx, r, a, b;
    prod = pos * TABLE_DEPTH;
    idx = prod >> FRAC_BITS;
    r = prod & 64'(ONE - 1);
    if (idx >= TABLE_DEPTH) return use_exp ? exp_tab[TABLE_DEPTH] : sin_tab[TABLE_DEPTH];
    a = use_exp ? exp_tab[idx] : sin_tab[idx];
    b = use_exp ? exp_tab[idx + 1] : sin_tab[idx + 1];
    if (b >= a) return a + (((b - a) * r) >> FRAC_BITS);
    return a - (((a - b) * r) >> FRAC_BITS);
  endfunction

  // 2^(-u/ONE), u up to ten times ONE.
  function automatic longint two_pow_neg(input logic [63:0] u);
    logic [63:0] e30, sh;
    e30 = lerp(1'b1, u & 64'(ONE - 1));
    sh = 64'(30 - FRAC_BITS) + (u >> FRAC_BITS);
    return longint'((e30 + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint overshoot_in(input logic [63:0] x);
    logic [63:0] half, a, b, mag, mag30, q, m;
    half = 64'd1 << (FRAC_BITS - 1);
    a = (64'd1827057613 + (64'd1 << 30)) * x;
    b = 64'd1827057613 << FRAC_BITS;
    mag = (a < b) ? b - a : a - b;
    mag30 = (mag + half) >> FRAC_BITS;
    q = (x * x + half) >> FRAC_BITS;
    m = (mag30 * q + 64'd536870912) >> 30;
    return (a < b) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint bounce_out(input logic [63:0] x);
    logic [63:0] m, off, d;
    if (11 * x < 4 * ONE) begin m = 0; off = 0; end
    else if (11 * x < 8 * ONE) begin m = 12; off = (3 * ONE) / 4; end
    else if (11 * x < 10 * ONE) begin m = 18; off = (15 * ONE) / 16; end
    else begin m = 21; off = (63 * ONE) / 64; end
    d = (22 * x >= m * ONE) ? 22 * x - m * ONE : m * ONE - 22 * x;
    return longint'(((d * d + (64'd1 << (FRAC_BITS + 5))) >> (FRAC_BITS + 6)) + off);
  endfunction

  function automatic logic signed [LEVEL_W-1:0] shaped_level(
      input logic [CURVE_W-1:0] sel, input logic [PHASE_W-1:0] ph);
    logic [63:0] x;
    longint      lv;
    x = 64'(ph);
    if (x > ONE) x = ONE;
    case (sel)
      CURVE_SINE:      lv = longint'((lerp(1'b0, x) + (64'd1 << (29 - FRAC_BITS)))
                             >> (30 - FRAC_BITS));
      CURVE_EXP:       lv = two_pow_neg(10 * (ONE - x));
      CURVE_LOG:       lv = ONE - two_pow_neg(10 * x);
      CURVE_STEP_NOW:  lv = ONE;
      CURVE_STEP_WAIT: lv = (x >= STEP_THRESH) ? ONE : 0;
      CURVE_IN_BACK:   lv = overshoot_in(x);
      CURVE_OUT_BACK:  lv = ONE - overshoot_in(ONE - x);
      default:         lv = bounce_out(x);
    endcase
    if (lv < -2 * ONE) lv = -2 * ONE;
    if (lv > 2 * ONE - 1) lv = 2 * ONE - 1;
    return LEVEL_W'(lv);
  endfunction

  assign pending = level_q.size();

  always @(posedge clk) begin
    logic signed [LEVEL_W-1:0] want;
    if (rst) begin
      cur_curve <= CURVE_SINE;
      fail_count <= 0;
      levels_seen <= 0;
      level_q.delete();
    end else begin
      // A result leaving now was queued before this edge, so pop first.
      if (done) begin
        levels_seen <= levels_seen + 1;
        if (level_q.size() == 0) begin
          $error("unexpected level %0d", level);
          fail_count <= fail_count + 1;
        end else begin
          want = level_q.pop_front();
          if (level !== want) begin
            $error("field level: expected %0d, actual %0d", want, level);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) level_q.push_back(shaped_level(cur_curve, phase));
      if (curve_select_we) cur_curve <= curve_select;
    end
  end

endmodule

### bench/testbench.sv
// Top of the easing curve shaper bench: clock, reset, stimulus and verdict.
module testbench;
  import ecs_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [PHASE_W-1:0]        phase;
  logic                      curve_select_we;
  logic [CURVE_W-1:0]        curve_select;
  logic                      done;
  logic signed [LEVEL_W-1:0] level;
  int                        fail_count;
  int                        pending;
  int                        levels_seen;
  int                        quiet_cycles;
  int                        phases_sent;

  easing_curve_shaper_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .phase(phase),
    .curve_select_we(curve_select_we), .curve_select(curve_select),
    .done(done), .level(level)
  );

  curve_check u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .phase(phase),
    .curve_select_we(curve_select_we), .curve_select(curve_select),
    .done(done), .level(level), .fail_count(fail_count),
    .pending(pending), .levels_seen(levels_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("easing_curve_shaper_unit: mismatch");
      $finish;
    end
  end

  // Drive one phase at a falling edge and hold start until the block takes it.
  task automatic send_phase(input logic [PHASE_W-1:0] ph);
    start <= 1'b1;
    phase <= ph;
    @(posedge clk);
    while (busy) @(posedge clk);
    phases_sent++;
    @(negedge clk);
  endtask

  // Drop start for a random burst of idle cycles.
  task automatic idle_burst();
    int n;
    n = $urandom_range(18, 1);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Change the curve only once the pipeline has drained.
  task automatic pick_curve(input logic [CURVE_W-1:0] sel);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    curve_select_we <= 1'b1;
    curve_select <= sel;
    @(negedge clk);
    curve_select_we <= 1'b0;
  endtask

  // Mostly in-range phases, with corners, values above one and full noise mixed in.
  function automatic logic [PHASE_W-1:0] random_phase();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return PHASE_W'($urandom_range(ONE, 0));
    if (r < 80) return PHASE_W'($urandom_range(ONE, ONE - 64));
    if (r < 88) return PHASE_W'($urandom_range(64, 0));
    return PHASE_W'($urandom());
  endfunction

  initial begin
    logic [PHASE_W-1:0] corners[12];
    rst = 1'b1;
    start = 1'b0;
    phase = '0;
    curve_select_we = 1'b0;
    curve_select = CURVE_SINE;
    quiet_cycles = 0;
    phases_sent = 0;
    corners = '{PHASE_W'(0), PHASE_W'(1), PHASE_W'(ONE / 2), PHASE_W'(ONE - 1),
                PHASE_W'(ONE), PHASE_W'(ONE + 1), PHASE_W'(STEP_THRESH - 1),
                PHASE_W'(STEP_THRESH), PHASE_W'((4 * ONE) / 11 + 1),
                PHASE_W'((8 * ONE) / 11 + 1), PHASE_W'((10 * ONE) / 11 + 1),
                {PHASE_W{1'b1}}};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: run the corners through every curve, starting from the reset sine.
    for (int c = 0; c < 8; c++) begin
      if (c != 0) pick_curve(CURVE_W'(c));
      foreach (corners[i]) send_phase(corners[i]);
      if (c == 0) send_phase(PHASE_W'(ONE / 4));
    end

    // Random phases in blocks per curve; gaps stop in the last blocks.
    for (int blk = 0; blk < 40; blk++) begin
      pick_curve((blk < 8) ? CURVE_W'(blk) : CURVE_W'($urandom_range(7, 0)));
      for (int n = 0; n < 50; n++) begin
        if (blk < 34 && $urandom_range(5, 0) == 0) idle_burst();
        send_phase(random_phase());
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d phases over all eight curves, checked %0d levels.",
             phases_sent, levels_seen);
    if (fail_count == 0) begin
      $display("easing_curve_shaper_unit: match");
    end else begin
      $display("easing_curve_shaper_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/ecs_pkg.sv
sv/ecs_interp.sv
sv/ecs_poly.sv
sv/easing_curve_shaper_unit.sv
bench/curve_check.sv
bench/testbench.sv
